/* hw/rtl/i2cbw_pkg.sv */
// Package for the I2C master byte writer: sequencer phase codes, input mode
// codes and the bundle of sequencer state shared by the step logic and top level.
// No dependencies.
`default_nettype none

package i2cbw_pkg;

   // Sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_CHECK = 4'd1,
      PH_ST_D1    = 4'd2,
      PH_ST_D2    = 4'd3,
      PH_ST_D3    = 4'd4,
      PH_SP_D1    = 4'd5,
      PH_SP_D2    = 4'd6,
      PH_SP_D3    = 4'd7,
      PH_WB_LOW   = 4'd8,
      PH_WB_STR   = 4'd9,
      PH_WB_HIGH  = 4'd10,
      PH_AK_LOW   = 4'd11,
      PH_AK_STR   = 4'd12,
      PH_AK_HIGH  = 4'd13
   } phase_type;

   // Item kinds carried on the request side
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam logic CSR_HALF_PERIOD   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   localparam int HALF_W    = 10;
   localparam int STRETCH_W = 12;

   localparam logic [HALF_W-1:0]    HALF_PERIOD_RST   = 10'd42;
   localparam logic [STRETCH_W-1:0] STRETCH_LIMIT_RST = 12'd690;
   localparam logic [3:0]           BITS_PER_BYTE     = 4'd8;

   // Sequencer state
   typedef struct packed {
      phase_type             phase;
      logic [7:0]            shift_byte;
      logic [3:0]            bit_count;
      logic [HALF_W-1:0]     wait_count;
      logic [STRETCH_W-1:0]  stretch_count;
      logic                  scl_low;
      logic                  sda_low;
      logic                  nack;
   } seq_state_type;

   // Per-item flags from the step logic
   typedef struct packed {
      logic done;
      logic status;
   } step_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/i2cbw_step.sv */
// Next-state logic of the I2C write sequencer: advances one item (tick or
// command) given the current state and the sampled pins. Uses i2cbw_pkg.
`default_nettype none

module i2cbw_step
   import i2cbw_pkg::*;
(
   input  seq_state_type          cur,
   input  mode_type               mode,
   input  logic [7:0]             data_byte,
   input  logic                   scl_in,
   input  logic                   sda_in,
   input  logic [HALF_W-1:0]      half_period,
   input  logic [STRETCH_W-1:0]   stretch_limit,
   output seq_state_type          nxt,
   output step_flags_type         flags
);

   logic                 delay_end;
   logic [HALF_W-1:0]    wait_dec;
   logic                 stretch_end;
   logic [STRETCH_W-1:0] stretch_inc;
   logic [3:0]           bit_inc;

   // Delay and stretch counters
   assign delay_end   = (cur.wait_count <= HALF_W'(1));
   assign wait_dec    = delay_end ? '0 : cur.wait_count - HALF_W'(1);
   assign stretch_end = scl_in || (cur.stretch_count >= stretch_limit);
   assign stretch_inc = cur.stretch_count + STRETCH_W'(1);
   assign bit_inc     = cur.bit_count + 4'd1;

   // Advance one item
   always_comb begin
      nxt          = cur;
      flags.done   = 1'b0;
      flags.status = 1'b0;
      case (cur.phase)
         PH_ST_CHECK: begin
            if (!sda_in) begin
               flags.done   = 1'b1;
               flags.status = 1'b1;
               nxt.phase    = PH_IDLE;
            end else begin
               nxt.wait_count = half_period;
               nxt.phase      = PH_ST_D1;
            end
         end
         PH_ST_D1, PH_ST_D2, PH_SP_D1, PH_SP_D2: begin
            nxt.wait_count = wait_dec;
            if (delay_end) begin
               nxt.wait_count = half_period;
               case (cur.phase)
                  PH_ST_D1: begin
                     nxt.sda_low = 1'b1;
                     nxt.phase   = PH_ST_D2;
                  end
                  PH_ST_D2: begin
                     nxt.scl_low = 1'b1;
                     nxt.phase   = PH_ST_D3;
                  end
                  PH_SP_D1: begin
                     nxt.scl_low = 1'b0;
                     nxt.phase   = PH_SP_D2;
                  end
                  default: begin
                     nxt.sda_low = 1'b0;
                     nxt.phase   = PH_SP_D3;
                  end
               endcase
            end
         end
         PH_ST_D3, PH_SP_D3, PH_AK_HIGH: begin
            nxt.wait_count = wait_dec;
            if (delay_end) begin
               flags.done = 1'b1;
               nxt.phase  = PH_IDLE;
            end
         end
         PH_WB_LOW, PH_AK_LOW: begin
            nxt.wait_count = wait_dec;
            if (delay_end) begin
               nxt.scl_low       = 1'b0;
               nxt.stretch_count = '0;
               nxt.phase         = (cur.phase == PH_WB_LOW) ? PH_WB_STR : PH_AK_STR;
            end
         end
         PH_WB_STR, PH_AK_STR: begin
            if (stretch_end) begin
               nxt.wait_count = half_period;
               if (cur.phase == PH_WB_STR) begin
                  nxt.phase = PH_WB_HIGH;
               end else begin
                  nxt.nack  = sda_in;
                  nxt.phase = PH_AK_HIGH;
               end
            end else begin
               nxt.stretch_count = stretch_inc;
            end
         end
         PH_WB_HIGH: begin
            nxt.wait_count = wait_dec;
            if (delay_end) begin
               nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
               nxt.bit_count  = bit_inc;
               nxt.scl_low    = 1'b1;
               nxt.wait_count = half_period;
               if (bit_inc >= BITS_PER_BYTE) begin
                  // release SDA for the acknowledge clock
                  nxt.sda_low = 1'b0;
                  nxt.phase   = PH_AK_LOW;
               end else begin
                  nxt.sda_low = ~cur.shift_byte[6];
                  nxt.phase   = PH_WB_LOW;
               end
            end
         end
         default: begin
            // idle: take a command, drop a tick
            nxt.phase = PH_IDLE;
            case (mode)
               MODE_START: begin
                  nxt.scl_low = 1'b0;
                  nxt.sda_low = 1'b0;
                  nxt.phase   = PH_ST_CHECK;
               end
               MODE_STOP: begin
                  nxt.scl_low    = 1'b1;
                  nxt.sda_low    = 1'b1;
                  nxt.wait_count = half_period;
                  nxt.phase      = PH_SP_D1;
               end
               MODE_WRITE: begin
                  nxt.shift_byte = data_byte;
                  nxt.bit_count  = '0;
                  nxt.scl_low    = 1'b1;
                  nxt.sda_low    = ~data_byte[7];
                  nxt.wait_count = half_period;
                  nxt.phase      = PH_WB_LOW;
               end
               default: begin
                  nxt.phase = PH_IDLE;
               end
            endcase
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_byte_writer.sv */
// I2C master byte writer top level: request/response streams, configuration
// registers, sequencer state and the result register. Uses i2cbw_pkg, i2cbw_step.
`default_nettype none

// Open-drain I2C master for start, stop and byte-write sequences. Each request
// transfer is one timing tick (tuser = 0) or a command (1 start, 2 stop,
// 3 write byte) together with the sampled SCL and SDA pin levels; every request
// gives exactly one response with the line drives, ready, done, nack and
// status. Commands are taken only while ready is shown; a command while busy
// counts as a tick. The block takes one request per clock cycle into the
// response register; a request is taken whenever the response register is
// empty or is being drained in the same cycle, so rate is set only by the
// response side's tready. Write half_period and stretch_limit only while no
// command is in progress.
module i2c_master_byte_writer
   import i2cbw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [8] scl_in, [9] sda_in
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] scl_drive_low, [1] sda_drive_low,
                                         // [2] ready_res, [3] done_res, [4] nack,
                                         // [5] status
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_data
);

   logic [HALF_W-1:0]    half_period_ff;
   logic [STRETCH_W-1:0] stretch_limit_ff;
   seq_state_type        state_ff;
   seq_state_type        state_in;
   step_flags_type       flags;
   logic                 rsp_valid_ff;
   logic [5:0]           rsp_data_ff;
   logic [5:0]           rsp_data_in;
   logic                 req_xfer;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RST;
         stretch_limit_ff <= STRETCH_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD:   half_period_ff   <= csr_data[HALF_W-1:0];
            CSR_STRETCH_LIMIT: stretch_limit_ff <= csr_data;
            default:           half_period_ff   <= half_period_ff;
         endcase
      end
   end

   // Accept while the response register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   i2cbw_step u_step (
      .cur           (state_ff),
      .mode          (mode_type'(req_tuser)),
      .data_byte     (req_tdata[7:0]),
      .scl_in        (req_tdata[8]),
      .sda_in        (req_tdata[9]),
      .half_period   (half_period_ff),
      .stretch_limit (stretch_limit_ff),
      .nxt           (state_in),
      .flags         (flags)
   );

   assign rsp_data_in = {flags.status, state_in.nack, flags.done,
                         (state_in.phase == PH_IDLE),
                         state_in.sda_low, state_in.scl_low};

   // Sequencer state: advance on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, default: '0};
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // Checks
   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[3]) |-> rsp_data_ff[2])
      else $error("done reported while sequencer not idle");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[5]) |-> rsp_data_ff[3])
      else $error("start abort reported without done");

   a_check_lines_released: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_ST_CHECK) |-> (!state_ff.scl_low && !state_ff.sda_low))
      else $error("lines driven during start check");

   a_busy_no_new_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && state_ff.phase == PH_WB_LOW) |=> (state_ff.phase == PH_WB_LOW
         || state_ff.phase == PH_WB_STR))
      else $error("bit low phase left to an unexpected phase");

endmodule

`default_nettype wire
